// ===== hdl/cce_pkg.sv =====
// cce_pkg: shared types, constants and gamma table generators for the contrast enforcer
// depends on nothing; used by cce_blend_enc and color_contrast_enforcer
`timescale 1ns / 1ps

package cce_pkg;

    localparam int unsigned MC_W    = 13;
    localparam int unsigned COLOR_W = 24;
    localparam int unsigned CODE_W  = 8;
    localparam int unsigned LANES   = 3;

    localparam logic [MC_W-1:0] MC_RESET = 13'd1152;

    // luminance weights in q16, summing to one
    localparam logic [15:0] W_RED   = 16'd13933;
    localparam logic [15:0] W_GREEN = 16'd46871;
    localparam logic [15:0] W_BLUE  = 16'd4732;

    localparam longint unsigned Q30_ONE  = 64'd1 << 30;
    localparam longint unsigned TOE_D_F  = 64'd255 * 64'd1292;
    localparam longint unsigned TOE_D_H  = 64'd510 * 64'd1292;
    localparam longint unsigned POW_D_F  = 64'd255 * 64'd1055;
    localparam longint unsigned POW_D_H  = 64'd510 * 64'd1055;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LUM,
        S_YREG,
        S_TEST,
        S_ENC,
        S_ENC_WAIT,
        S_FALL,
        S_DONE
    } cce_state_t;

    typedef enum logic [2:0] {
        PH_BG,
        PH_FG,
        PH_FULL,
        PH_MID,
        PH_FINAL
    } cce_phase_t;

    typedef struct packed {
        logic start;
        logic lighten;
    } cce_enc_req_t;

    // truncated fifth power in uq2.30
    function automatic longint unsigned pow5_q30(longint unsigned r);
        longint unsigned a;
        longint unsigned b;
        a = (r * r) >> 30;
        b = (a * a) >> 30;
        return (b * r) >> 30;
    endfunction

    // srgb to linear in uq2.30, elaboration only; half selects (2c+1)/510 over c/255
    function automatic longint unsigned lin_q30(int unsigned c, bit half);
        longint unsigned num;
        longint unsigned den;
        longint unsigned a;
        longint unsigned x;
        longint unsigned t;
        longint unsigned s;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        num = half ? (2 * longint'(c) + 1) : longint'(c);
        den = half ? 64'd510 : 64'd255;
        if (num * 100000 <= den * 4045)
        begin
            a = (num * 100) << 30;
            x = half ? (a + TOE_D_H / 2) / TOE_D_H : (a + TOE_D_F / 2) / TOE_D_F;
        end
        else
        begin
            a = (num * 1000 + den * 55) << 30;
            t = half ? (a + POW_D_H / 2) / POW_D_H : (a + POW_D_F / 2) / POW_D_F;
            s = (t * t) >> 30;
            lo = 0;
            hi = Q30_ONE;
            for (int i = 0; i < 32; i++)
            begin
                if (lo < hi)
                begin
                    mid = (lo + hi + 1) >> 1;
                    if (pow5_q30(mid) <= s)
                        lo = mid;
                    else
                        hi = mid - 1;
                end
            end
            x = (s * lo) >> 30;
        end
        return x;
    endfunction

endpackage

// ===== hdl/cce_in_if.sv =====
// cce_in_if: input channel carrying a foreground and background color pair
// depends on nothing
`timescale 1ns / 1ps

interface cce_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] fg_color;
    logic [23:0] bg_color;

    modport source (output valid, output fg_color, output bg_color, input ready);
    modport sink   (input valid, input fg_color, input bg_color, output ready);
endinterface

// ===== hdl/cce_out_if.sv =====
// cce_out_if: output channel carrying the adjusted foreground color
// depends on nothing
`timescale 1ns / 1ps

interface cce_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] result_color;

    modport source (output valid, output result_color, input ready);
    modport sink   (input valid, input result_color, output ready);
endinterface

// ===== hdl/cce_blend_enc.sv =====
// cce_blend_enc: blends three linear channels toward white or black and
// re-encodes them to srgb codes by a bitwise search of the threshold table; uses cce_pkg
`timescale 1ns / 1ps

module cce_blend_enc #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  cce_pkg::cce_enc_req_t                       req,
    input  logic [32:0]                                 k,
    input  logic [2:0][FRACTION_BITS:0]                 lin,
    output logic                                        done,
    output logic [23:0]                                 code
);
    import cce_pkg::*;

    localparam int LW = FRACTION_BITS + 1;
    localparam int PW = LW + 33;
    localparam logic [LW-1:0] ONE = LW'(64'd1 << FRACTION_BITS);

    typedef logic [LW-1:0] thr_rom_t [256];

    function automatic thr_rom_t build_thr();
        thr_rom_t rom;
        longint unsigned q;
        for (int c = 0; c < 256; c++)
        begin
            if (c < 255)
            begin
                q = lin_q30(c, 1'b1);
                rom[c] = LW'((q + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS));
            end
            else
                rom[c] = '1;
        end
        return rom;
    endfunction

    localparam thr_rom_t THR_ROM = build_thr();

    logic                  busy_reg;
    logic                  done_reg;
    logic [7:0]            bit_reg;
    logic [LW-1:0]         n_reg   [LANES];
    logic [CODE_W-1:0]     pos_reg [LANES];
    logic [LW-1:0]         n_next  [LANES];
    logic [CODE_W-1:0]     pos_next[LANES];

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        logic [LW-1:0]     mul_a;
        logic [PW-1:0]     prod;
        logic [PW-1:0]     rnd;
        logic [LW-1:0]     delta;
        logic [CODE_W-1:0] cand;

        // one multiplier per lane, rounded at 32 fraction bits
        assign mul_a = req.lighten ? (ONE - lin[i]) : lin[i];
        assign prod  = PW'(mul_a) * PW'(k);
        assign rnd   = prod + (PW'(1) << 31);
        assign delta = rnd[32 +: LW];
        assign n_next[i] = req.lighten ? (lin[i] + delta) : (lin[i] - delta);

        assign cand = pos_reg[i] | bit_reg;
        assign pos_next[i] = (THR_ROM[cand - 8'd1] <= n_reg[i]) ? cand : pos_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                bit_reg  <= 8'h80;
            end
            else if (busy_reg)
            begin
                bit_reg <= bit_reg >> 1;
                if (bit_reg[0])
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (req.start)
            begin
                n_reg[i]   <= n_next[i];
                pos_reg[i] <= '0;
            end
            else if (busy_reg)
                pos_reg[i] <= pos_next[i];
        end
    end

    assign done = done_reg;
    assign code = {pos_reg[0], pos_reg[1], pos_reg[2]};

endmodule

// ===== hdl/color_contrast_enforcer.sv =====
// color_contrast_enforcer: top level, sequencer, luminance mac and ratio test
// depends on cce_pkg, cce_in_if, cce_out_if and cce_blend_enc
`timescale 1ns / 1ps

// Takes a foreground/background srgb pair and returns a foreground whose
// contrast ratio against the background is at least min_contrast (8 fraction
// bits). A foreground that already passes comes back unchanged. Otherwise the
// foreground is blended toward white or black (the lighter way first when the
// background is dark), the full blend is tried, and the blend factor is binary
// searched for SEARCH_STEPS steps; failing both ways, white or black is
// returned. Each candidate goes through a blend step, a threshold-table search
// over eight bits (all three channels at once, then a done strobe), the single
// luminance multiply-accumulate over the three channels, a register for the
// luminance and a ratio compare. The block takes one item at a time and
// in_ch.ready is low while it works. The finished color sits in an output
// register, so the next pair can be taken while it waits for a transfer.
module color_contrast_enforcer #(
    parameter int SEARCH_STEPS  = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [cce_pkg::MC_W-1:0]    cfg_wr_data,
    cce_in_if.sink                      in_ch,
    cce_out_if.source                   out_ch
);
    import cce_pkg::*;

    localparam int LW  = FRACTION_BITS + 1;       // linear values reach one inclusive
    localparam int SW  = $clog2(SEARCH_STEPS);
    localparam int AW  = LW + 17;                 // luminance accumulator
    localparam int OW  = LW + 1;                  // value plus offset
    localparam int RW  = LW + 15;                 // ratio compare
    localparam logic [LW-1:0] ONE  = LW'(64'd1 << FRACTION_BITS);
    localparam logic [LW-1:0] HALF = LW'(64'd1 << (FRACTION_BITS - 1));
    localparam logic [LW-1:0] OFF  = LW'(((64'd1 << FRACTION_BITS) + 64'd10) / 64'd20);
    localparam logic [2*OW-1:0] W_CONTRAST = (2*OW)'(
        ((64'd1 << FRACTION_BITS) + ((64'd1 << FRACTION_BITS) + 64'd10) / 64'd20)
        * (((64'd1 << FRACTION_BITS) + 64'd10) / 64'd20));
    localparam logic [32:0] FULL = 33'h1_0000_0000;

    typedef logic [LW-1:0] lin_rom_t [256];

    function automatic lin_rom_t build_dec();
        lin_rom_t rom;
        longint unsigned q;
        for (int c = 0; c < 256; c++)
        begin
            q = lin_q30(c, 1'b0);
            rom[c] = LW'((q + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS));
        end
        return rom;
    endfunction

    localparam lin_rom_t DEC_ROM = build_dec();

    // control
    cce_state_t          state_reg, state_next;
    cce_phase_t          phase_reg;
    logic [1:0]          cnt_reg;
    logic [SW-1:0]       step_reg;
    logic                pass_reg;
    logic                dir_reg;
    logic                out_valid_reg;

    // payload
    logic [MC_W-1:0]     mc_reg;
    logic [COLOR_W-1:0]  fg_reg;
    logic [COLOR_W-1:0]  code_reg;
    logic [COLOR_W-1:0]  res_reg;
    logic [COLOR_W-1:0]  out_reg;
    logic [AW-1:0]       acc_reg;
    logic [LW-1:0]       y_reg;
    logic [LW-1:0]       bgy_reg;
    logic [32:0]         k_reg;
    logic [32:0]         lo_reg;
    logic [32:0]         hi_reg;

    // datapath wires
    logic                in_xfer;
    logic                out_free;
    logic                load_out;
    cce_enc_req_t        enc_req;
    logic                enc_done;
    logic [COLOR_W-1:0]  enc_code;
    logic [2:0][LW-1:0]  fg_lin;
    logic [CODE_W-1:0]   lum_code;
    logic [15:0]         lum_w;
    logic [LW-1:0]       y_hi;
    logic [LW-1:0]       y_lo;
    logic [RW-1:0]       lhs;
    logic [RW-1:0]       rhs;
    logic                met;
    logic [OW-1:0]       bg_off;
    logic [2*OW-1:0]     b_contrast;
    logic [32:0]         lo_new;
    logic [32:0]         hi_new;
    logic [33:0]         mid_sum;
    logic                last_step;

    // decoded foreground channels, fixed for the whole item
    assign fg_lin[0] = DEC_ROM[fg_reg[23:16]];
    assign fg_lin[1] = DEC_ROM[fg_reg[15:8]];
    assign fg_lin[2] = DEC_ROM[fg_reg[7:0]];

    // luminance mac: one channel per cycle, red first
    always_comb
    begin
        case (cnt_reg)
            2'd0:    begin lum_code = code_reg[23:16]; lum_w = W_RED;   end
            2'd1:    begin lum_code = code_reg[15:8];  lum_w = W_GREEN; end
            default: begin lum_code = code_reg[7:0];   lum_w = W_BLUE;  end
        endcase
    end

    // ratio test by cross multiplication
    assign y_hi = (y_reg > bgy_reg) ? y_reg : bgy_reg;
    assign y_lo = (y_reg > bgy_reg) ? bgy_reg : y_reg;
    assign lhs  = RW'({(OW'(y_hi) + OW'(OFF)), 8'd0});
    assign rhs  = RW'(mc_reg) * RW'(OW'(y_lo) + OW'(OFF));
    assign met  = lhs >= rhs;

    // fallback: white wins ties
    assign bg_off     = OW'(bgy_reg) + OW'(OFF);
    assign b_contrast = (2*OW)'(bg_off) * (2*OW)'(bg_off);

    // search update
    assign lo_new    = met ? lo_reg : k_reg;
    assign hi_new    = met ? k_reg  : hi_reg;
    assign mid_sum   = {1'b0, lo_new} + {1'b0, hi_new};
    assign last_step = step_reg == SW'(SEARCH_STEPS - 1);

    assign in_xfer  = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign load_out = (state_reg == S_DONE) && out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_ch.valid)
                    state_next = S_LUM;
            S_LUM:
                if (cnt_reg == 2'd2)
                    state_next = S_YREG;
            S_YREG:
                state_next = S_TEST;
            S_TEST:
                case (phase_reg)
                    PH_BG:   state_next = S_LUM;
                    PH_FG:   state_next = met ? S_DONE : S_ENC;
                    PH_FULL: state_next = (met || !pass_reg) ? S_ENC : S_FALL;
                    default: state_next = S_ENC;
                endcase
            S_ENC:
                state_next = S_ENC_WAIT;
            S_ENC_WAIT:
                if (enc_done)
                    state_next = (phase_reg == PH_FINAL) ? S_DONE : S_LUM;
            S_FALL:
                state_next = S_DONE;
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ch.ready     = 1'b0;
        enc_req.start   = 1'b0;
        enc_req.lighten = dir_reg;
        case (state_reg)
            S_IDLE:  in_ch.ready   = 1'b1;
            S_ENC:   enc_req.start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_BG;
            cnt_reg       <= '0;
            step_reg      <= '0;
            pass_reg      <= 1'b0;
            dir_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            mc_reg        <= MC_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                mc_reg <= cfg_wr_data;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    phase_reg <= PH_BG;
                    cnt_reg   <= '0;
                end
                S_LUM:
                    cnt_reg <= (cnt_reg == 2'd2) ? 2'd0 : cnt_reg + 2'd1;
                S_TEST:
                    case (phase_reg)
                        PH_BG:
                            phase_reg <= PH_FG;
                        PH_FG:
                        begin
                            // lighten first on a dark background
                            dir_reg   <= bgy_reg < HALF;
                            pass_reg  <= 1'b0;
                            phase_reg <= PH_FULL;
                        end
                        PH_FULL:
                            if (met)
                            begin
                                step_reg  <= '0;
                                phase_reg <= PH_MID;
                            end
                            else
                            begin
                                pass_reg <= 1'b1;
                                dir_reg  <= !dir_reg;
                            end
                        PH_MID:
                        begin
                            step_reg <= step_reg + SW'(1);
                            if (last_step)
                                phase_reg <= PH_FINAL;
                        end
                        default: ;
                    endcase
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            fg_reg   <= in_ch.fg_color;
            code_reg <= in_ch.bg_color;
            acc_reg  <= AW'(32768);
        end
        if (load_out)
            out_reg <= res_reg;
        case (state_reg)
            S_LUM:
                acc_reg <= acc_reg + AW'(lum_w) * AW'(DEC_ROM[lum_code]);
            S_YREG:
                y_reg <= acc_reg[16 +: LW];
            S_TEST:
                case (phase_reg)
                    PH_BG:
                    begin
                        bgy_reg  <= y_reg;
                        code_reg <= fg_reg;
                        acc_reg  <= AW'(32768);
                    end
                    PH_FG:
                    begin
                        res_reg <= fg_reg;
                        k_reg   <= FULL;
                    end
                    PH_FULL:
                    begin
                        lo_reg <= '0;
                        hi_reg <= FULL;
                        k_reg  <= met ? (FULL >> 1) : FULL;
                    end
                    PH_MID:
                    begin
                        lo_reg <= lo_new;
                        hi_reg <= hi_new;
                        k_reg  <= last_step ? hi_new : mid_sum[33:1];
                    end
                    default: ;
                endcase
            S_ENC_WAIT:
                if (enc_done)
                begin
                    code_reg <= enc_code;
                    res_reg  <= enc_code;
                    acc_reg  <= AW'(32768);
                end
            S_FALL:
                res_reg <= (W_CONTRAST >= b_contrast) ? 24'hFF_FFFF : 24'h00_0000;
            default: ;
        endcase
    end

    cce_blend_enc #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_blend_enc (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (enc_req),
        .k     (k_reg),
        .lin   (fg_lin),
        .done  (enc_done),
        .code  (enc_code)
    );

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result_color = out_reg;

endmodule
